>>> design/pss_pkg.sv
// Shared constants and types for the partial shuffle sampler.
`timescale 1ns / 1ps

package pss_pkg;

	localparam int MAX_RANGE = 256;
	localparam int IDX_W = $clog2(MAX_RANGE);
	localparam int CNT_W = $clog2(MAX_RANGE + 1);
	localparam int WORD_W = 32;
	localparam int PICK_W = 9;
	localparam int CMP_W = (CNT_W > PICK_W) ? CNT_W : PICK_W;
	localparam int DIV_CNT_W = $clog2(WORD_W);
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_RANGE_START = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_END = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PICK_COUNT = 2'd2;

	localparam logic [WORD_W-1:0] RANGE_START_RST = 32'd0;
	localparam logic [WORD_W-1:0] RANGE_END_RST = 32'd255;
	localparam logic [PICK_W-1:0] PICK_COUNT_RST = 9'd8;

	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [WORD_W-1:0] word_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

>>> design/pss_div.sv
// Bit-serial remainder unit: one quotient bit per cycle.
`timescale 1ns / 1ps

module pss_div (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  pss_pkg::word_t    dividend,
	input  pss_pkg::cnt_t     divisor,
	output pss_pkg::div_stat_t stat,
	output pss_pkg::cnt_t     remainder
);

	logic                          busy_q;
	logic                          done_q;
	logic [pss_pkg::DIV_CNT_W-1:0] cnt_q;
	pss_pkg::word_t                num_q;
	pss_pkg::cnt_t                 den_q;
	pss_pkg::cnt_t                 rem_q;
	logic [pss_pkg::CNT_W:0]       shifted;
	logic [pss_pkg::CNT_W:0]       trial;

	assign shifted = {rem_q, num_q[pss_pkg::WORD_W-1]};
	assign trial = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= pss_pkg::DIV_CNT_W'(pss_pkg::WORD_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[pss_pkg::WORD_W-2:0], 1'b0};
			if (shifted >= {1'b0, den_q}) begin
				rem_q <= trial[pss_pkg::CNT_W-1:0];
			end else begin
				rem_q <= shifted[pss_pkg::CNT_W-1:0];
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign remainder = rem_q;

endmodule

>>> design/partial_shuffle_sampler_unit.sv
// Top level of the partial shuffle sampler: sequencer, offset table and result register.
// Each request carries one random word and yields one drawn value without repetition
// from range_start..range_end, using a partial Fisher-Yates shuffle over an offset table.
// A request with a valid range passes through a check state, a setup state, the bit-serial
// remainder unit (its iterations and then its done strobe), the table states RD_A, RD_B,
// RD_C and WR_T on a table with one read port and one write port, and the output state.
// A request with a bad range goes from the check state straight to the output state. The
// block is ready again in the cycle after its output register loads. One request is in
// flight at a time; the next may be accepted while the previous result still waits to be taken.
`timescale 1ns / 1ps

module partial_shuffle_sampler_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [pss_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pss_pkg::WORD_W-1:0]       cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [pss_pkg::WORD_W-1:0]       random_word,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic signed [pss_pkg::WORD_W-1:0] drawn_value,
	output logic                             last_of_run,
	output logic                             range_error
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_CHECK = 4'd1;
	localparam logic [3:0] ST_PREP = 4'd2;
	localparam logic [3:0] ST_DIV = 4'd3;
	localparam logic [3:0] ST_RD_A = 4'd4;
	localparam logic [3:0] ST_RD_B = 4'd5;
	localparam logic [3:0] ST_RD_C = 4'd6;
	localparam logic [3:0] ST_WR_T = 4'd7;
	localparam logic [3:0] ST_EMIT = 4'd8;

	logic [3:0] state_q;

	logic signed [pss_pkg::WORD_W-1:0] range_start_q;
	logic signed [pss_pkg::WORD_W-1:0] range_end_q;
	logic [pss_pkg::PICK_W-1:0]        pick_count_q;

	pss_pkg::word_t             word_q;
	pss_pkg::cnt_t              n_q;
	pss_pkg::cnt_t              count_q;
	pss_pkg::cnt_t              dd_q;
	pss_pkg::cnt_t              den_c;
	logic [pss_pkg::IDX_W-1:0]  pick_q;
	logic [pss_pkg::IDX_W-1:0]  tail_q;
	logic [pss_pkg::IDX_W-1:0]  chosen_q;
	logic [pss_pkg::MAX_RANGE-1:0] written_q;

	pss_pkg::word_t res_value_q;
	logic           res_last_q;
	logic           res_err_q;
	logic           out_valid_q;
	pss_pkg::word_t out_value_q;
	logic           out_last_q;
	logic           out_err_q;

	logic [pss_pkg::IDX_W-1:0] table_mem [pss_pkg::MAX_RANGE];
	logic [pss_pkg::IDX_W-1:0] rd_q;
	logic [pss_pkg::IDX_W-1:0] mem_raddr;
	logic [pss_pkg::IDX_W-1:0] mem_waddr;
	logic [pss_pkg::IDX_W-1:0] mem_wdata;
	logic                      mem_we;

	logic [33:0]               size_c;
	logic                      size_bad;
	logic [pss_pkg::CMP_W-1:0] pc_c;
	logic [pss_pkg::CMP_W-1:0] nc_c;
	pss_pkg::cnt_t             count_c;
	pss_pkg::cnt_t             dd_eff_c;
	pss_pkg::cnt_t             tail_c;
	pss_pkg::cnt_t             dd_next_c;
	logic [pss_pkg::IDX_W-1:0] moved_c;
	logic                      div_start;
	pss_pkg::div_stat_t        div_stat;
	pss_pkg::cnt_t             div_rem;

	pss_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (word_q),
		.divisor   (den_c),
		.stat      (div_stat),
		.remainder (div_rem)
	);

	assign size_c = {{2{range_end_q[pss_pkg::WORD_W-1]}}, range_end_q}
		- {{2{range_start_q[pss_pkg::WORD_W-1]}}, range_start_q} + 34'd1;
	assign size_bad = size_c[33] || (size_c == 34'd0) || (size_c > 34'(pss_pkg::MAX_RANGE));

	assign pc_c = (pick_count_q == '0) ? pss_pkg::CMP_W'(1) : pss_pkg::CMP_W'(pick_count_q);
	assign nc_c = pss_pkg::CMP_W'(n_q);
	assign count_c = (pc_c > nc_c) ? n_q : pc_c[pss_pkg::CNT_W-1:0];
	assign dd_eff_c = (dd_q >= count_c) ? '0 : dd_q;
	assign den_c = n_q - dd_eff_c;
	assign tail_c = n_q - dd_eff_c - pss_pkg::CNT_W'(1);
	assign dd_next_c = dd_q + pss_pkg::CNT_W'(1);
	assign moved_c = written_q[tail_q] ? rd_q : tail_q;

	assign div_start = (state_q == ST_PREP);
	assign in_ready = (state_q == ST_IDLE);

	assign mem_raddr = (state_q == ST_RD_A) ? pick_q : tail_q;
	assign mem_we = (state_q == ST_RD_C) || (state_q == ST_WR_T);
	assign mem_waddr = (state_q == ST_RD_C) ? pick_q : tail_q;
	assign mem_wdata = (state_q == ST_RD_C) ? moved_c : chosen_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			table_mem[mem_waddr] <= mem_wdata;
		end
		rd_q <= table_mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_start_q <= pss_pkg::RANGE_START_RST;
			range_end_q <= pss_pkg::RANGE_END_RST;
			pick_count_q <= pss_pkg::PICK_COUNT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				pss_pkg::REG_RANGE_START: range_start_q <= cfg_data;
				pss_pkg::REG_RANGE_END: range_end_q <= cfg_data;
				pss_pkg::REG_PICK_COUNT: pick_count_q <= cfg_data[pss_pkg::PICK_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			dd_q <= '0;
			written_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_EMIT) && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (size_bad) begin
						dd_q <= '0;
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					dd_q <= dd_eff_c;
					if (dd_eff_c == '0) begin
						written_q <= '0;
					end
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_stat.done) begin
						state_q <= ST_RD_A;
					end
				end
				ST_RD_A: state_q <= ST_RD_B;
				ST_RD_B: state_q <= ST_RD_C;
				ST_RD_C: begin
					written_q[pick_q] <= 1'b1;
					state_q <= ST_WR_T;
				end
				ST_WR_T: begin
					written_q[tail_q] <= 1'b1;
					dd_q <= (dd_next_c >= count_q) ? '0 : dd_next_c;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (!out_valid_q || out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				word_q <= random_word;
			end
			ST_CHECK: begin
				n_q <= size_c[pss_pkg::CNT_W-1:0];
				res_value_q <= '0;
				res_last_q <= 1'b1;
				res_err_q <= 1'b1;
			end
			ST_PREP: begin
				count_q <= count_c;
				tail_q <= tail_c[pss_pkg::IDX_W-1:0];
			end
			ST_DIV: begin
				pick_q <= div_rem[pss_pkg::IDX_W-1:0];
			end
			ST_RD_B: begin
				chosen_q <= written_q[pick_q] ? rd_q : pick_q;
			end
			ST_WR_T: begin
				res_value_q <= range_start_q + pss_pkg::WORD_W'(chosen_q);
				res_last_q <= (dd_next_c >= count_q);
				res_err_q <= 1'b0;
			end
			ST_EMIT: begin
				if (!out_valid_q || out_ready) begin
					out_value_q <= res_value_q;
					out_last_q <= res_last_q;
					out_err_q <= res_err_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign drawn_value = out_value_q;
	assign last_of_run = out_last_q;
	assign range_error = out_err_q;

endmodule

>>> design/pss_chk.sv
// Port-level checker for the partial shuffle sampler, bound to the top level.
`timescale 1ns / 1ps

module pss_chk (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic signed [pss_pkg::WORD_W-1:0] drawn_value,
	input logic                              last_of_run,
	input logic                              range_error
);

	// An accepted request keeps the block busy on the following cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted again right after a request");

	// A result that is not taken holds its contents.
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(drawn_value)
			&& $stable(last_of_run) && $stable(range_error))
		else $error("pending result changed before it was taken");

	// A range error always ends the run.
	a_error_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && range_error |-> last_of_run)
		else $error("range error without end of run");

	// A range error carries a zero value.
	a_error_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && range_error |-> drawn_value == '0)
		else $error("range error with a nonzero value");

endmodule

bind partial_shuffle_sampler_unit pss_chk u_pss_chk (.*);

>>> dv/tb_partial_shuffle_sampler_unit.sv
// Testbench for the partial shuffle sampler: directed table, then predicted random runs.
`timescale 1ns / 1ps

module tb_partial_shuffle_sampler_unit;

	typedef struct packed {
		logic signed [pss_pkg::WORD_W-1:0] value;
		logic last;
		logic err;
	} draw_t;

	typedef enum logic {ROW_WRITE, ROW_DRAW} row_kind_t;

	typedef struct {
		row_kind_t kind;
		logic [pss_pkg::CFG_IDX_W-1:0] index;
		pss_pkg::word_t data;
		bit known;
		draw_t want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [pss_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	pss_pkg::word_t cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	pss_pkg::word_t random_word = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [pss_pkg::WORD_W-1:0] drawn_value;
	logic last_of_run;
	logic range_error;

	logic signed [pss_pkg::WORD_W-1:0] lo_bound = pss_pkg::RANGE_START_RST;
	logic signed [pss_pkg::WORD_W-1:0] hi_bound = pss_pkg::RANGE_END_RST;
	logic [pss_pkg::PICK_W-1:0] draws_per_run = pss_pkg::PICK_COUNT_RST;
	logic [pss_pkg::IDX_W-1:0] slot_offset [pss_pkg::MAX_RANGE];
	bit slot_taken [pss_pkg::MAX_RANGE];
	int drawn_so_far = 0;

	draw_t pending_draws [$];
	row_t plan [$];
	int fail_count = 0;
	int sent = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	bit hold_armed = 1'b0;
	bit hold_taken = 1'b0;
	int hold_left = 0;

	partial_shuffle_sampler_unit uut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("Verification failed");
		$finish;
	end

	function automatic draw_t next_draw(pss_pkg::word_t word);
		longint span;
		int n, quota, left, sel, tail;
		logic [pss_pkg::IDX_W-1:0] chosen, moved;
		draw_t d;
		span = longint'(hi_bound) - longint'(lo_bound) + 1;
		if (span < 1 || span > pss_pkg::MAX_RANGE) begin
			drawn_so_far = 0;
			d.value = '0;
			d.last = 1'b1;
			d.err = 1'b1;
			return d;
		end
		n = int'(span);
		quota = (draws_per_run == 0) ? 1 : int'(draws_per_run);
		if (quota > n)
			quota = n;
		if (drawn_so_far >= quota)
			drawn_so_far = 0;
		if (drawn_so_far == 0)
			foreach (slot_taken[i])
				slot_taken[i] = 1'b0;
		left = n - drawn_so_far;
		sel = int'(longint'(word) % left);
		tail = n - 1 - drawn_so_far;
		chosen = slot_taken[sel] ? slot_offset[sel] : pss_pkg::IDX_W'(sel);
		moved = slot_taken[tail] ? slot_offset[tail] : pss_pkg::IDX_W'(tail);
		slot_offset[sel] = moved;
		slot_taken[sel] = 1'b1;
		slot_offset[tail] = chosen;
		slot_taken[tail] = 1'b1;
		drawn_so_far++;
		d.last = (drawn_so_far >= quota);
		if (d.last)
			drawn_so_far = 0;
		d.value = lo_bound + pss_pkg::WORD_W'(chosen);
		d.err = 1'b0;
		return d;
	endfunction

	function automatic void plan_write(logic [pss_pkg::CFG_IDX_W-1:0] index,
		pss_pkg::word_t data);
		plan.push_back('{ROW_WRITE, index, data, 1'b0, '0});
	endfunction

	function automatic void plan_draw(pss_pkg::word_t word, bit known, draw_t want);
		plan.push_back('{ROW_DRAW, '0, word, known, want});
	endfunction

	function automatic pss_pkg::word_t rand_word();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2: return pss_pkg::word_t'($urandom_range(300));
			default: return $urandom;
		endcase
	endfunction

	// Registers change only once every outstanding request has returned its result.
	task automatic write_reg(logic [pss_pkg::CFG_IDX_W-1:0] index, pss_pkg::word_t data);
		in_valid <= 1'b0;
		while (pending_draws.size() != 0)
			@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		case (index)
			pss_pkg::REG_RANGE_START: lo_bound = data;
			pss_pkg::REG_RANGE_END: hi_bound = data;
			pss_pkg::REG_PICK_COUNT: draws_per_run = data[pss_pkg::PICK_W-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic offer_word(pss_pkg::word_t word, bit known, draw_t want);
		draw_t predicted;
		cfg_we <= 1'b0;
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		random_word <= word;
		do
			@(posedge clk);
		while (in_ready !== 1'b1);
		predicted = next_draw(word);
		pending_draws.push_back(known ? want : predicted);
		sent++;
	endtask

	task automatic new_setting(bit keep_range);
		int roll, span, jitter;
		longint base, top;
		pss_pkg::word_t pick_word;
		span = 8;
		roll = $urandom_range(99);
		base = longint'($signed($urandom));
		jitter = $urandom_range(1000);
		if (roll < 5) begin
			top = base - 1 - (jitter % 40);
		end else if (roll < 10) begin
			top = base + pss_pkg::MAX_RANGE + jitter;
		end else begin
			roll = $urandom_range(99);
			if (roll < 70)
				span = $urandom_range(16, 1);
			else if (roll < 90)
				span = $urandom_range(255, 17);
			else
				span = pss_pkg::MAX_RANGE;
			roll = $urandom_range(3);
			jitter = $urandom_range(3);
			if (roll == 0)
				base = 64'sh7FFF_FFFF - span + 1 - jitter;
			else if (roll == 1)
				base = -64'sh8000_0000 + jitter;
			if (base + span - 1 > 64'sh7FFF_FFFF)
				base = 64'sh7FFF_FFFF - span + 1;
			top = base + span - 1;
		end
		roll = $urandom_range(99);
		if (roll < 55)
			pick_word = span;
		else if (roll < 80)
			pick_word = $urandom_range(span, 1);
		else if (roll < 95)
			pick_word = $urandom_range(511);
		else
			pick_word = '0;
		if ($urandom_range(3) == 0)
			pick_word[pss_pkg::WORD_W-1:pss_pkg::PICK_W] =
				(pss_pkg::WORD_W - pss_pkg::PICK_W)'($urandom);
		if (!keep_range) begin
			write_reg(pss_pkg::REG_RANGE_START, pss_pkg::word_t'(base));
			write_reg(pss_pkg::REG_RANGE_END, pss_pkg::word_t'(top));
		end
		write_reg(pss_pkg::REG_PICK_COUNT, pick_word);
	endtask

	always @(posedge clk) begin
		if (hold_armed && !hold_taken) begin
			hold_left = 400;
			hold_taken = 1'b1;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		draw_t want;
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			if (pending_draws.size() == 0) begin
				$display("%0t: unexpected result, expected none, got value %0d last %0b error %0b",
					$time, drawn_value, last_of_run, range_error);
				fail_count++;
			end else begin
				want = pending_draws.pop_front();
				if (drawn_value !== want.value) begin
					$display("%0t: drawn_value expected %0d got %0d", $time, want.value,
						drawn_value);
					fail_count++;
				end
				if (last_of_run !== want.last) begin
					$display("%0t: last_of_run expected %0b got %0b", $time, want.last,
						last_of_run);
					fail_count++;
				end
				if (range_error !== want.err) begin
					$display("%0t: range_error expected %0b got %0b", $time, want.err,
						range_error);
					fail_count++;
				end
			end
		end
	end

	initial begin
		draw_t none;
		int phase, burst;
		none = '0;

		plan_draw(32'h0000_0000, 1'b1, '{32'sd0, 1'b0, 1'b0});
		plan_draw(32'hFFFF_FFFF, 1'b0, none);
		plan_draw(32'h8000_0001, 1'b0, none);
		plan_write(pss_pkg::REG_PICK_COUNT, 32'd1);
		plan_draw(32'd5, 1'b1, '{32'sd5, 1'b1, 1'b0});
		plan_write(pss_pkg::REG_RANGE_START, 32'h8000_0000);
		plan_write(pss_pkg::REG_RANGE_END, 32'h8000_0000);
		plan_draw(32'hFFFF_FFFF, 1'b1, '{32'sh8000_0000, 1'b1, 1'b0});
		plan_write(pss_pkg::REG_RANGE_END, 32'h7FFF_FFFF);
		plan_draw(32'h0000_0000, 1'b1, '{32'sd0, 1'b1, 1'b1});
		plan_write(pss_pkg::REG_RANGE_START, 32'h7FFF_FFFF);
		plan_draw(32'h0000_1234, 1'b1, '{32'sh7FFF_FFFF, 1'b1, 1'b0});
		plan_write(pss_pkg::REG_RANGE_START, 32'd10);
		plan_write(pss_pkg::REG_RANGE_END, 32'd9);
		plan_draw(32'd1, 1'b1, '{32'sd0, 1'b1, 1'b1});
		plan_write(pss_pkg::REG_RANGE_START, 32'd0);
		plan_write(pss_pkg::REG_RANGE_END, 32'd256);
		plan_draw(32'd2, 1'b1, '{32'sd0, 1'b1, 1'b1});
		plan_write(pss_pkg::REG_RANGE_END, 32'd255);
		plan_write(pss_pkg::REG_PICK_COUNT, 32'd0);
		plan_draw(32'd7, 1'b1, '{32'sd7, 1'b1, 1'b0});
		plan_write(pss_pkg::REG_RANGE_START, 32'hFFFF_FF80);
		plan_write(pss_pkg::REG_RANGE_END, 32'd127);
		plan_write(pss_pkg::REG_PICK_COUNT, 32'd256);
		plan_draw(32'hFFFF_FFFF, 1'b0, none);
		plan_draw(32'hAAAA_AAAA, 1'b0, none);
		plan_draw(32'h5555_5555, 1'b0, none);
		plan_write(pss_pkg::REG_RANGE_START, 32'd0);
		plan_write(pss_pkg::REG_RANGE_END, 32'd3);
		plan_draw(32'd0, 1'b0, none);
		plan_write(pss_pkg::REG_PICK_COUNT, 32'h0000_01FF);
		repeat (4)
			plan_draw(rand_word(), 1'b0, none);
		plan_write(pss_pkg::REG_PICK_COUNT, 32'hFFFF_FE02);
		repeat (2)
			plan_draw(rand_word(), 1'b0, none);

		repeat (11)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_WRITE)
				write_reg(plan[i].index, plan[i].data);
			else
				offer_word(plan[i].data, plan[i].known, plan[i].want);
		end

		phase = 0;
		while (sent < 430) begin
			new_setting(phase != 0 && $urandom_range(99) < 15);
			case (phase % 4)
				0: begin
					idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct = 53;
					stall_pct = 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct = 53;
				end
				default: begin
					idle_pct = 14;
					stall_pct = 14;
				end
			endcase
			// The receiver holds off for a long stretch here while requests keep coming.
			if (phase == 4)
				hold_armed = 1'b1;
			burst = $urandom_range(45, 20);
			repeat (burst)
				offer_word(rand_word(), 1'b0, none);
			phase++;
		end

		in_valid <= 1'b0;
		while (pending_draws.size() != 0)
			@(posedge clk);
		repeat (50)
			@(posedge clk);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

>>> files.f
design/pss_pkg.sv
design/pss_div.sv
design/partial_shuffle_sampler_unit.sv
design/pss_chk.sv
dv/tb_partial_shuffle_sampler_unit.sv
